// ===== hdl/stbs_pkg.sv =====
// ----------------------------------------------------------------------------
// stbs_pkg
// shared types and constants of the sorted table search block
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = ADDR_W + 1;
    localparam int KEY_W       = 32;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // one request as held in the queue
    typedef struct packed {
        logic                     op;
        logic [ADDR_W-1:0]        entry_index;
        logic signed [KEY_W-1:0]  value;
    } stbs_req_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic       valid;
        stbs_req_t  req;
    } stbs_head_t;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } stbs_state_t;

endpackage

// ===== hdl/stbs_front.sv =====
// ----------------------------------------------------------------------------
// stbs_front
// accepts requests, tags their kind and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module stbs_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               op,
    input  logic [stbs_pkg::ADDR_W-1:0]        entry_index,
    input  logic signed [stbs_pkg::KEY_W-1:0]  value,
    output stbs_pkg::stbs_head_t               head,
    input  logic                               pop
);

    stbs_pkg::stbs_req_t slot_reg [2];
    logic [1:0]          count_reg;
    logic [1:0]          count_next;
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic                push;
    logic                do_pop;
    stbs_pkg::stbs_req_t in_req;

    always_comb
    begin
        in_req.op          = (op == stbs_pkg::OP_SEARCH) ? stbs_pkg::OP_SEARCH
                                                          : stbs_pkg::OP_LOAD;
        in_req.entry_index = entry_index;
        in_req.value       = value;
    end

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign do_pop   = pop && (count_reg != 2'd0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_req;
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.req   = slot_reg[rd_ptr_reg];

endmodule

// ===== hdl/stbs_back.sv =====
// ----------------------------------------------------------------------------
// stbs_back
// table memory, iterative binary search and result register
// ----------------------------------------------------------------------------
module stbs_back
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  stbs_pkg::stbs_head_t               head,
    output logic                               pop,
    input  logic [stbs_pkg::COUNT_W-1:0]       entry_count,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               found,
    output logic [stbs_pkg::ADDR_W-1:0]        match_index
);

    logic signed [stbs_pkg::KEY_W-1:0] mem [stbs_pkg::TABLE_DEPTH];
    logic signed [stbs_pkg::KEY_W-1:0] rdata_reg;
    logic [stbs_pkg::ADDR_W-1:0]       rd_addr;
    logic                              mem_we;

    stbs_pkg::stbs_state_t             state_reg, state_next;
    logic [stbs_pkg::COUNT_W-1:0]      limit_reg, limit_next;
    logic [stbs_pkg::COUNT_W-1:0]      base_reg, base_next;
    logic [stbs_pkg::ADDR_W-1:0]       n_reg, n_next;
    logic [stbs_pkg::COUNT_W-1:0]      probe_reg, probe_next;
    logic signed [stbs_pkg::KEY_W-1:0] key_reg, key_next;

    logic                              out_valid_reg, out_valid_next;
    logic                              found_reg, found_next;
    logic [stbs_pkg::ADDR_W-1:0]       match_index_reg, match_index_next;

    logic [stbs_pkg::COUNT_W-1:0]      clamp;
    logic                              probe_oor;
    logic                              hit;
    logic                              key_gt;
    logic [stbs_pkg::COUNT_W-1:0]      base_adv;
    logic [stbs_pkg::ADDR_W-1:0]       n_half;
    logic [stbs_pkg::COUNT_W-1:0]      probe_adv;
    logic                              finish;
    logic                              out_free;

    // counts above the table depth act as a full table
    assign clamp = (entry_count > stbs_pkg::COUNT_W'(stbs_pkg::TABLE_DEPTH))
                   ? stbs_pkg::COUNT_W'(stbs_pkg::TABLE_DEPTH) : entry_count;

    // probe past the live range counts as greater than any key
    assign probe_oor = (probe_reg >= limit_reg);
    assign hit       = !probe_oor && (key_reg == rdata_reg);
    assign key_gt    = !probe_oor && (key_reg > rdata_reg);
    assign base_adv  = key_gt ? (probe_reg + stbs_pkg::COUNT_W'(1)) : base_reg;
    assign n_half    = n_reg >> 1;
    assign probe_adv = base_adv + stbs_pkg::COUNT_W'(n_half);
    assign finish    = hit || (n_reg == '0);
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next       = state_reg;
        limit_next       = limit_reg;
        base_next        = base_reg;
        n_next           = n_reg;
        probe_next       = probe_reg;
        key_next         = key_reg;
        rd_addr          = probe_reg[stbs_pkg::ADDR_W-1:0];
        mem_we           = 1'b0;
        pop              = 1'b0;
        out_valid_next   = out_valid_reg && out_stall;
        found_next       = found_reg;
        match_index_next = match_index_reg;

        case (state_reg)
            stbs_pkg::ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (head.req.op == stbs_pkg::OP_LOAD)
                    begin
                        mem_we = 1'b1;
                    end
                    else
                    begin
                        limit_next = clamp;
                        base_next  = '0;
                        n_next     = clamp[stbs_pkg::COUNT_W-1:1];
                        probe_next = stbs_pkg::COUNT_W'(clamp[stbs_pkg::COUNT_W-1:1]);
                        key_next   = head.req.value;
                        rd_addr    = clamp[stbs_pkg::COUNT_W-1:1];
                        state_next = stbs_pkg::ST_SEARCH;
                    end
                end
            end
            stbs_pkg::ST_SEARCH:
            begin
                if (finish)
                begin
                    // hold the probe and its read data until the result slot frees
                    if (out_free)
                    begin
                        out_valid_next   = 1'b1;
                        found_next       = hit;
                        match_index_next = hit ? probe_reg[stbs_pkg::ADDR_W-1:0] : '0;
                        state_next       = stbs_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    base_next  = base_adv;
                    n_next     = n_half;
                    probe_next = probe_adv;
                    rd_addr    = probe_adv[stbs_pkg::ADDR_W-1:0];
                end
            end
            default:
            begin
                state_next = stbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[head.req.entry_index] <= head.req.value;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stbs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        limit_reg       <= limit_next;
        base_reg        <= base_next;
        n_reg           <= n_next;
        probe_reg       <= probe_next;
        key_reg         <= key_next;
        found_reg       <= found_next;
        match_index_reg <= match_index_next;
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign match_index = match_index_reg;

endmodule

// ===== hdl/sorted_table_binary_search_core.sv =====
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core
// sorted table of signed 32-bit entries with binary search lookup
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) carries one request: op, entry_index,
//   value. op load writes value at entry_index and gives no result; op search
//   looks value up among the first entry_count entries, which software loads
//   in ascending order beforehand.
//   output channel (out_valid / out_stall) gives one result per search:
//   found and match_index (0 on a miss). the user must write entry_count
//   over the apb port at address 0 while idle; the block does not enforce it.
// operation:
//   a search leaves the queue while the engine is idle and makes one probe
//   per cycle, up to floor(log2(count)) + 1 probes, then waits for a free
//   result slot; a load writes the table as it leaves the queue. the table
//   memory has a single read port, used once per probe. a two-entry request
//   queue lets the sender keep going while a search runs.
// reset:
//   clears entry_count, the queue and the result valid flag; table contents
//   stay undefined until loaded.
// stall:
//   a stalled result holds in its register; the search engine then waits
//   and the queue fills, after which in_stall rises.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    // request channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               op,
    input  logic [stbs_pkg::ADDR_W-1:0]        entry_index,
    input  logic signed [stbs_pkg::KEY_W-1:0]  value,
    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               found,
    output logic [stbs_pkg::ADDR_W-1:0]        match_index,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic [stbs_pkg::COUNT_W-1:0] entry_count_reg;
    logic                         cfg_write;
    logic                         pop;
    stbs_pkg::stbs_head_t         head;

    // register map: entry_count at byte addresses 0 to 3 (only paddr[2] is decoded), nothing else
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? 32'(entry_count_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            entry_count_reg <= pwdata[stbs_pkg::COUNT_W-1:0];
        end
    end

    // front: accept and queue requests
    stbs_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .entry_index (entry_index),
        .value       (value),
        .head        (head),
        .pop         (pop)
    );

    // back: table memory, search engine and result register
    stbs_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .entry_count (entry_count_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .match_index (match_index)
    );

endmodule
